/* rtl/quad_dds_toggle_generator_assert.svh */
// assertion macros used by the toggle generator top level
`ifndef QUAD_DDS_TOGGLE_GENERATOR_ASSERT_SVH
`define QUAD_DDS_TOGGLE_GENERATOR_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked out of reset
`define QDDS_ASSERT_NOW(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("qdds assertion failed");

// next-cycle implication, checked out of reset
`define QDDS_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("qdds assertion failed");

`else

`define QDDS_ASSERT_NOW(label, clk, rst, cond, prop)
`define QDDS_ASSERT_NEXT(label, clk, rst, cond, prop)

`endif

`endif

/* rtl/qdds_pkg.sv */
// types and constants of the quad toggle generator
`timescale 1ns / 1ps

package qdds_pkg;

   localparam int CHANNELS         = 4;
   localparam int RAW_WIDTH        = 16;
   localparam int STEP_WIDTH       = 17;
   localparam int PHASE_WIDTH      = 32;
   localparam int MASK_WIDTH       = 16;
   localparam int WORD_WIDTH       = 2 * MASK_WIDTH;
   localparam int TOGGLES_PER_TURN = 48;

   typedef logic [RAW_WIDTH-1:0]   raw_type;
   typedef logic [STEP_WIDTH-1:0]  step_type;
   typedef logic [PHASE_WIDTH-1:0] phase_type;
   typedef logic [MASK_WIDTH-1:0]  mask_type;
   typedef logic [WORD_WIDTH-1:0]  word_type;
   typedef logic [1:0]             csr_index_type;
   typedef logic [CHANNELS-1:0]    levels_type;

   // configuration register indexes
   localparam csr_index_type CSR_PIN_MASK_0 = 2'd0;
   localparam csr_index_type CSR_PIN_MASK_1 = 2'd1;
   localparam csr_index_type CSR_PIN_MASK_2 = 2'd2;
   localparam csr_index_type CSR_PIN_MASK_3 = 2'd3;

   // pin mask reset values
   localparam mask_type PIN_MASK_0_RESET = 16'h0100;
   localparam mask_type PIN_MASK_1_RESET = 16'h8000;
   localparam mask_type PIN_MASK_2_RESET = 16'h0001;
   localparam mask_type PIN_MASK_3_RESET = 16'h0040;

   // one toggle interval, 2^32 / toggles per turn, wrapped to 32 bits
   localparam logic [63:0] TOGGLE_INTERVAL_FULL = (64'd1 << 32) / 64'(TOGGLES_PER_TURN);
   localparam phase_type   TOGGLE_INTERVAL      = TOGGLE_INTERVAL_FULL[PHASE_WIDTH-1:0];

   // step = floor(raw * 2^32 / 3e9) as raw * ceil(2^71 / 3e9) >> 39,
   // exact over the whole 16-bit raw range
   localparam int          STEP_SHIFT     = 39;
   localparam logic [95:0] STEP_MULT_FULL =
      ((96'd1 << (32 + STEP_SHIFT)) + 96'd2999999999) / 96'd3000000000;
   localparam int          MULT_HALF      = 20;
   localparam logic [MULT_HALF-1:0] STEP_MULT_LO = STEP_MULT_FULL[MULT_HALF-1:0];
   localparam logic [MULT_HALF-1:0] STEP_MULT_HI = STEP_MULT_FULL[2*MULT_HALF-1:MULT_HALF];

   // per-channel status toward the result word
   typedef struct packed {
      logic level;
      logic drive_high;
   } chan_status_type;

endpackage

/* rtl/qdds_step.sv */
// speed to phase step conversion by reciprocal multiply
`timescale 1ns / 1ps

module qdds_step (
   input  qdds_pkg::raw_type  raw_speed,
   output qdds_pkg::step_type step
);

   localparam int ProdWidth = qdds_pkg::RAW_WIDTH + qdds_pkg::MULT_HALF;
   localparam int SumWidth  = ProdWidth + qdds_pkg::MULT_HALF;

   logic [ProdWidth-1:0] prod_lo;
   logic [ProdWidth-1:0] prod_hi;
   logic [SumWidth-1:0]  prod_sum;

   // two 16 by 20 partial products of the constant reciprocal
   assign prod_lo = ProdWidth'(raw_speed) * ProdWidth'(qdds_pkg::STEP_MULT_LO);
   assign prod_hi = ProdWidth'(raw_speed) * ProdWidth'(qdds_pkg::STEP_MULT_HI);

   assign prod_sum = (SumWidth'(prod_hi) << qdds_pkg::MULT_HALF) + SumWidth'(prod_lo);

   assign step = prod_sum[qdds_pkg::STEP_SHIFT +: qdds_pkg::STEP_WIDTH];

endmodule

/* rtl/qdds_channel.sv */
// one channel: phase accumulator, edge tracker and toggle level
`timescale 1ns / 1ps

module qdds_channel (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      advance,
   input  qdds_pkg::step_type        step,
   output qdds_pkg::chan_status_type status
);

   qdds_pkg::phase_type phase_ff, phase_in;
   qdds_pkg::phase_type edge_ff, edge_in;
   logic                level_ff, level_in;

   qdds_pkg::phase_type phase_sum;
   qdds_pkg::phase_type phase_diff;
   logic                active;
   logic                crossed;

   // phase advance and signed edge compare
   always_comb begin
      active     = (step != '0);
      phase_sum  = phase_ff + qdds_pkg::PHASE_WIDTH'(step);
      phase_diff = phase_sum - edge_ff;
      crossed    = active && !phase_diff[qdds_pkg::PHASE_WIDTH-1];
   end

   // next state, frozen while stopped
   always_comb begin
      phase_in = phase_ff;
      edge_in  = edge_ff;
      level_in = level_ff;
      if (active) begin
         phase_in = phase_sum;
      end
      if (crossed) begin
         edge_in  = edge_ff + qdds_pkg::TOGGLE_INTERVAL;
         level_in = ~level_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
         edge_ff  <= qdds_pkg::TOGGLE_INTERVAL;
         level_ff <= 1'b0;
      end else if (advance) begin
         phase_ff <= phase_in;
         edge_ff  <= edge_in;
         level_ff <= level_in;
      end
   end

   // level after this tick; a stopped channel drives low
   assign status.level      = level_in;
   assign status.drive_high = active && level_in;

endmodule

/* rtl/quad_dds_toggle_generator.sv */
// top level of the four-channel square-wave toggle generator
`timescale 1ns / 1ps
`include "quad_dds_toggle_generator_assert.svh"

// Four-channel phase-accumulator square-wave generator.
// Request channel: one beat per sample tick with four raw speeds
// (req_raw_speed_0..3), handshake req_valid / req_stall.
// Response channel: one beat per request with the set/reset word and the
// stored channel levels, handshake rsp_valid / rsp_stall.
// Configuration: csr_write_enable writes csr_write_data into pin mask
// csr_index at the clock edge; write only while no beat is in flight.
// Pipeline: a taken request loads the step stage and moves on to the response
// register when that register is empty or its beat is taken. The first stage
// registers the phase steps from a constant reciprocal multiply, the
// second updates the channel state and loads the response register.
// Throughput: one beat per cycle while the response is not stalled.
// A stalled response holds its beat; one more request is taken into the
// step stage, then req_stall rises until the response moves.
// Reset: synchronous, clears the valid bits of both stages, sets phases
// to zero, edges to one toggle interval, levels low and pin masks to their defaults.

module quad_dds_toggle_generator (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  qdds_pkg::raw_type       req_raw_speed_0,
   input  qdds_pkg::raw_type       req_raw_speed_1,
   input  qdds_pkg::raw_type       req_raw_speed_2,
   input  qdds_pkg::raw_type       req_raw_speed_3,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output qdds_pkg::word_type      rsp_set_reset_word,
   output qdds_pkg::levels_type    rsp_channel_levels,
   input  logic                    csr_write_enable,
   input  qdds_pkg::csr_index_type csr_index,
   input  qdds_pkg::mask_type      csr_write_data
);

   qdds_pkg::raw_type         raw_speed [qdds_pkg::CHANNELS];
   qdds_pkg::step_type        step_calc [qdds_pkg::CHANNELS];
   qdds_pkg::step_type        step_ff   [qdds_pkg::CHANNELS];
   qdds_pkg::chan_status_type status    [qdds_pkg::CHANNELS];
   qdds_pkg::mask_type        pin_mask_ff [qdds_pkg::CHANNELS];

   logic                 step_valid_ff, step_valid_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   qdds_pkg::word_type   word_ff, word_in;
   qdds_pkg::levels_type levels_ff, levels_in;

   logic req_take;
   logic stage_move;

   assign raw_speed[0] = req_raw_speed_0;
   assign raw_speed[1] = req_raw_speed_1;
   assign raw_speed[2] = req_raw_speed_2;
   assign raw_speed[3] = req_raw_speed_3;

   // pipeline flow control
   assign stage_move    = step_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall     = step_valid_ff && !stage_move;
   assign req_take      = req_valid && !req_stall;
   assign step_valid_in = req_take || (step_valid_ff && !stage_move);
   assign rsp_valid_in  = stage_move || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         step_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         step_valid_ff <= step_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // pin mask registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pin_mask_ff[0] <= qdds_pkg::PIN_MASK_0_RESET;
         pin_mask_ff[1] <= qdds_pkg::PIN_MASK_1_RESET;
         pin_mask_ff[2] <= qdds_pkg::PIN_MASK_2_RESET;
         pin_mask_ff[3] <= qdds_pkg::PIN_MASK_3_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            qdds_pkg::CSR_PIN_MASK_0: pin_mask_ff[0] <= csr_write_data;
            qdds_pkg::CSR_PIN_MASK_1: pin_mask_ff[1] <= csr_write_data;
            qdds_pkg::CSR_PIN_MASK_2: pin_mask_ff[2] <= csr_write_data;
            qdds_pkg::CSR_PIN_MASK_3: pin_mask_ff[3] <= csr_write_data;
            default: ;
         endcase
      end
   end

   // step stage and channel state per channel
   for (genvar c = 0; c < qdds_pkg::CHANNELS; c++) begin : g_chan
      qdds_step u_step (
         .raw_speed (raw_speed[c]),
         .step      (step_calc[c])
      );

      always_ff @(posedge clock) begin
         if (req_take) begin
            step_ff[c] <= step_calc[c];
         end
      end

      qdds_channel u_channel (
         .clock   (clock),
         .reset   (reset),
         .advance (stage_move),
         .step    (step_ff[c]),
         .status  (status[c])
      );
   end

   // set/reset word and level bits
   always_comb begin
      word_in   = '0;
      levels_in = '0;
      for (int c = 0; c < qdds_pkg::CHANNELS; c++) begin
         if (status[c].drive_high) begin
            word_in = word_in | qdds_pkg::WORD_WIDTH'(pin_mask_ff[c]);
         end else begin
            word_in = word_in | (qdds_pkg::WORD_WIDTH'(pin_mask_ff[c]) << qdds_pkg::MASK_WIDTH);
         end
         levels_in[c] = status[c].level;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (stage_move) begin
         word_ff   <= word_in;
         levels_ff <= levels_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_set_reset_word = word_ff;
   assign rsp_channel_levels = levels_ff;

   // pipeline checks
   `QDDS_ASSERT_NOW(a_stall_needs_beat, clock, reset, req_stall, step_valid_ff && rsp_valid_ff)
   `QDDS_ASSERT_NEXT(a_move_loads_rsp, clock, reset, stage_move, rsp_valid_ff)
   `QDDS_ASSERT_NOW(a_free_rsp_no_stall, clock, reset, !rsp_valid_ff, !req_stall)
   `QDDS_ASSERT_NEXT(a_take_fills_step, clock, reset, req_take, step_valid_ff)

endmodule
